>>> hdl/mi3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;
    localparam int ElemW = 32;
    localparam int CofW  = 64;
    localparam int DetW  = 98;
    localparam int NumW  = 97;
    localparam int QW    = 34;
    localparam int ThrW  = 63;
    localparam int NElem = 9;

    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StSing = 2'd1;
    localparam logic [1:0] StSat  = 2'd2;

    typedef logic signed [ElemW-1:0] elem_t;
    typedef logic signed [CofW-1:0]  cof_t;

    // Work item from the front (cofactor/determinant) to the back (divider).
    typedef struct packed {
        cof_t [NElem-1:0]      cof;
        logic [DetW-1:0]       dmag;
        logic                  dneg;
        logic                  sing;
    } job_t;
endpackage
`default_nettype wire

>>> hdl/mi3_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mi3_front
    import mi3_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [ThrW-1:0]  min_abs_det,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire elem_t [NElem-1:0] in_a,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output job_t                  out_job
);
    // stage 1: 2x2 products; stage 2: cofactors; stage 3: det partial products
    // (element times cofactor high and low halves); stage 4: det sum;
    // stage 5: magnitude and threshold
    logic [4:0] v_reg;
    logic       adv;
    logic signed [2*ElemW-1:0] p_reg [18];
    logic signed [2*ElemW-1:0] p_next [18];
    elem_t [NElem-1:0] a1_reg, a2_reg;
    cof_t  [NElem-1:0] c2_reg, c3_reg, c4_reg;
    logic signed [2*ElemW-1:0] ph_reg [3];
    logic signed [2*ElemW:0]   pl_reg [3];
    logic signed [DetW-1:0] det_reg;
    job_t  j_reg;
    logic signed [DetW-1:0] det;
    logic [DetW-1:0] dmag;

    assign adv      = !v_reg[4] || out_ready;
    assign in_ready = adv;
    assign out_valid = v_reg[4];
    assign out_job  = j_reg;

    always_comb begin
        p_next[0]  = in_a[4] * in_a[8];  p_next[1]  = in_a[5] * in_a[7];
        p_next[2]  = in_a[2] * in_a[7];  p_next[3]  = in_a[1] * in_a[8];
        p_next[4]  = in_a[1] * in_a[5];  p_next[5]  = in_a[2] * in_a[4];
        p_next[6]  = in_a[5] * in_a[6];  p_next[7]  = in_a[3] * in_a[8];
        p_next[8]  = in_a[0] * in_a[8];  p_next[9]  = in_a[2] * in_a[6];
        p_next[10] = in_a[2] * in_a[3];  p_next[11] = in_a[0] * in_a[5];
        p_next[12] = in_a[3] * in_a[7];  p_next[13] = in_a[4] * in_a[6];
        p_next[14] = in_a[1] * in_a[6];  p_next[15] = in_a[0] * in_a[7];
        p_next[16] = in_a[0] * in_a[4];  p_next[17] = in_a[1] * in_a[3];
    end

    // a*c = a*c_hi*2^32 + a*c_lo, c_lo taken as unsigned
    assign det  = (DetW'(ph_reg[0]) <<< ElemW) + DetW'(pl_reg[0])
                + (DetW'(ph_reg[1]) <<< ElemW) + DetW'(pl_reg[1])
                + (DetW'(ph_reg[2]) <<< ElemW) + DetW'(pl_reg[2]);
    assign dmag = det_reg[DetW-1] ? DetW'(-det_reg) : DetW'(det_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
        if (adv) begin
            for (int i = 0; i < 18; i++) p_reg[i] <= p_next[i];
            a1_reg <= in_a;
            for (int i = 0; i < NElem; i++) c2_reg[i] <= p_reg[2*i] - p_reg[2*i+1];
            a2_reg <= a1_reg;
            for (int i = 0; i < 3; i++) begin
                ph_reg[i] <= a2_reg[i] * $signed(c2_reg[3*i][CofW-1:ElemW]);
                pl_reg[i] <= a2_reg[i] * $signed({1'b0, c2_reg[3*i][ElemW-1:0]});
            end
            c3_reg <= c2_reg;
            det_reg <= det;
            c4_reg <= c3_reg;
            j_reg.cof  <= c4_reg;
            j_reg.dmag <= dmag;
            j_reg.dneg <= det_reg[DetW-1];
            j_reg.sing <= (dmag <= DetW'(min_abs_det));
        end
    end
endmodule
`default_nettype wire

>>> hdl/mi3_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module mi3_queue
    import mi3_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire job_t in_job,
    output logic      out_valid,
    input  wire logic out_ready,
    output job_t      out_job
);
    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job   = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
        if (wr) mem_reg[wp_reg] <= in_job;
    end
endmodule
`default_nettype wire

>>> hdl/mi3_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mi3_back
    import mi3_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire job_t in_job,
    output logic      out_valid,
    input  wire logic out_ready,
    output elem_t [NElem-1:0] out_r,
    output logic [1:0] out_status
);
    // Pipelined restoring divider: quotient is at most QW bits wide once
    // saturated, so bits above are folded into a sticky overflow flag.
    localparam int S = QW;
    typedef struct packed {
        logic [NumW:0]  rem;
        logic [QW-1:0]  q;
        logic           ovf;
        logic           neg;
    } lane_t;

    logic [S:0] v_reg;
    lane_t [NElem-1:0] ln_reg [S+1];
    logic [DetW-1:0] d_reg [S+1];
    logic sg_reg [S+1];
    logic adv;
    logic [1:0] st_reg;
    elem_t [NElem-1:0] r_reg;
    logic ov_reg;

    assign adv = !ov_reg || out_ready;
    assign in_ready = adv;
    assign out_valid = ov_reg;
    assign out_r = r_reg;
    assign out_status = st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0; ov_reg <= 1'b0;
        end else if (adv) begin
            v_reg <= {v_reg[S-1:0], in_valid};
            ov_reg <= v_reg[S];
        end
        if (adv) begin
            d_reg[0] <= in_job.dmag;
            sg_reg[0] <= in_job.sing;
            for (int k = 0; k < NElem; k++) begin
                logic [CofW-1:0] cm;
                logic [DetW:0] num;
                logic [DetW:0] qhi;
                cm = in_job.cof[k][CofW-1] ? CofW'(-in_job.cof[k]) : CofW'(in_job.cof[k]);
                num = {3'b0, cm, 32'b0} + (DetW+1)'(in_job.dmag >> 1);
                // high quotient part (bits >= QW) nonzero iff num >= dmag<<QW
                qhi = num >> QW;
                ln_reg[0][k].ovf <= (qhi >= (DetW+1)'(in_job.dmag));
                ln_reg[0][k].rem <= (NumW+1)'(num);
                ln_reg[0][k].q   <= '0;
                ln_reg[0][k].neg <= in_job.cof[k][CofW-1] != in_job.dneg;
            end
            for (int s = 0; s < S; s++) begin
                d_reg[s+1] <= d_reg[s];
                sg_reg[s+1] <= sg_reg[s];
                for (int k = 0; k < NElem; k++) begin
                    logic [DetW+QW:0] dsh;
                    dsh = (DetW+QW+1)'(d_reg[s]) << (S-1-s);
                    ln_reg[s+1][k] <= ln_reg[s][k];
                    if (!ln_reg[s][k].ovf &&
                        (DetW+QW+1)'(ln_reg[s][k].rem) >= dsh) begin
                        ln_reg[s+1][k].rem <= (NumW+1)'((DetW+QW+1)'(ln_reg[s][k].rem) - dsh);
                        ln_reg[s+1][k].q[S-1-s] <= 1'b1;
                    end
                end
            end
            begin
                logic sat;
                sat = 1'b0;
                for (int k = 0; k < NElem; k++) begin
                    lane_t l;
                    l = ln_reg[S][k];
                    if (sg_reg[S]) r_reg[k] <= '0;
                    else if (l.neg) begin
                        if (l.ovf || l.q > QW'(33'h080000000)) begin
                            sat = 1'b1; r_reg[k] <= elem_t'(32'h80000000);
                        end else r_reg[k] <= elem_t'(-l.q[ElemW-1:0]);
                    end else begin
                        if (l.ovf || l.q > QW'(32'h7FFFFFFF)) begin
                            sat = 1'b1; r_reg[k] <= elem_t'(32'h7FFFFFFF);
                        end else r_reg[k] <= elem_t'(l.q[ElemW-1:0]);
                    end
                end
                st_reg <= sg_reg[S] ? StSing : (sat ? StSat : StOk);
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/matrix_inverse_3x3_top.sv
`timescale 1ns / 1ps
`default_nettype none
// 3x3 inverse by adjugate, Q16.16 in and out. One matrix per cycle while
// m_tready does not stall the pipeline. A request passes five front
// stages (products, cofactors, determinant partials, determinant sum,
// magnitude and threshold), the two-entry queue, a setup
// stage and 34 restoring divider stages per element, and an output register.
// |det| <= min_abs_det gives zeros with status 1; saturation status 2.
module matrix_inverse_3x3_top
    import mi3_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [63:0]  cfg_wr_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [287:0] s_tdata,  // a00..a22, 32 bits each
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [295:0]      m_tdata   // r00..r22, status[289:288]
);
    logic [ThrW-1:0] thr_reg;
    logic fv, fr, qv, qr;
    job_t fj, qj;
    elem_t [NElem-1:0] r;
    logic [1:0] st;

    always_ff @(posedge aclk) begin
        if (!aresetn) thr_reg <= '0;
        else if (cfg_wr_en) thr_reg <= cfg_wr_data[ThrW-1:0];
    end

    mi3_front u_front (.aclk, .aresetn, .min_abs_det(thr_reg), .in_valid(s_tvalid),
        .in_ready(s_tready), .in_a(s_tdata), .out_valid(fv), .out_ready(fr), .out_job(fj));
    mi3_queue u_q (.aclk, .aresetn, .in_valid(fv), .in_ready(fr), .in_job(fj),
        .out_valid(qv), .out_ready(qr), .out_job(qj));
    mi3_back u_back (.aclk, .aresetn, .in_valid(qv), .in_ready(qr), .in_job(qj),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_r(r), .out_status(st));

    assign m_tdata = {6'b0, st, r};

    a_st: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[289:288] != 2'd3) else $error("bad status");
    a_sing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[289:288] == StSing |-> m_tdata[287:0] == '0)
        else $error("singular nonzero");
endmodule
`default_nettype wire
